// ===== design/anbc_pkg.sv =====
package anbc_pkg;

   // ASCII codes
   localparam logic [7:0] CH_0  = 8'h30;
   localparam logic [7:0] CH_1  = 8'h31;
   localparam logic [7:0] CH_9  = 8'h39;
   localparam logic [7:0] CH_LB = 8'h62;
   localparam logic [7:0] CH_UB = 8'h42;
   localparam logic [7:0] CH_LX = 8'h78;
   localparam logic [7:0] CH_UX = 8'h58;
   localparam logic [7:0] CH_LA = 8'h61;
   localparam logic [7:0] CH_LF = 8'h66;
   localparam logic [7:0] CH_UA = 8'h41;
   localparam logic [7:0] CH_UF = 8'h46;
   localparam logic [7:0] CH_NUL = 8'h00;

   localparam logic [3:0] BIN_DIGIT_MAX = 4'd1;
   localparam logic [3:0] DEC_DIGIT_MAX = 4'd9;
   localparam logic [3:0] DEC_DIGIT_CNT = 4'd10;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_PREFIX   = 2'd1;
   localparam logic [1:0] ERR_DIGIT    = 2'd2;
   localparam logic [1:0] ERR_OVERFLOW = 2'd3;

   typedef enum logic [1:0] {
      BASE_NONE,
      BASE_BIN,
      BASE_DEC,
      BASE_HEX
   } base_type;

   typedef enum logic [1:0] {
      SEL_ZERO,
      SEL_BASE,
      SEL_DIGIT,
      SEL_ERROR
   } emit_sel_type;

   typedef struct packed {
      logic         take;
      logic         clear;
      logic         load;
      logic         shift;
      logic         emit;
      emit_sel_type sel;
   } anbc_cmd_type;

   typedef struct packed {
      logic [1:0] err;
      logic       out_free;
      logic       cnt_one;
      logic       top_zero;
   } anbc_status_type;

   // {is hex digit, digit value}; either letter case
   function automatic logic [4:0] digit_decode(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= CH_0 && c <= CH_9) begin
         r = {1'b1, 4'(c - CH_0)};
      end else if (c >= CH_LA && c <= CH_LF) begin
         r = {1'b1, 4'(c - CH_LA + 8'(DEC_DIGIT_CNT))};
      end else if (c >= CH_UA && c <= CH_UF) begin
         r = {1'b1, 4'(c - CH_UA + 8'(DEC_DIGIT_CNT))};
      end
      return r;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] d);
      logic [7:0] r;
      if (d < DEC_DIGIT_CNT) begin
         r = CH_0 + {4'b0, d};
      end else begin
         r = CH_UA + {4'b0, d} - {4'b0, DEC_DIGIT_CNT};
      end
      return r;
   endfunction

endpackage

// ===== design/anbc_dp.sv =====
module anbc_dp
   import anbc_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic [7:0]      req_char_in,
   input  logic            csr_write,
   input  logic            csr_wdata,
   input  anbc_cmd_type    cmd,
   output anbc_status_type status,
   input  logic            rsp_stall,
   output logic            rsp_valid,
   output logic [7:0]      rsp_char_out,
   output logic            rsp_run_end,
   output logic [1:0]      rsp_error
);

   localparam int PADW = ((VALUE_BITS + 3) / 4) * 4;
   localparam int CW   = $clog2(PADW + 1);
   localparam int EW   = VALUE_BITS + 4;

   logic                  out_hex_ff, out_hex_in;
   logic [1:0]            pos_ff, pos_in;
   base_type              base_ff, base_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [1:0]            err_ff, err_in;
   logic                  first_zero_ff, first_zero_in;
   logic [PADW-1:0]       sr_ff, sr_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_char_ff, rsp_char_in;
   logic                  rsp_end_ff, rsp_end_in;
   logic [1:0]            rsp_err_ff, rsp_err_in;

   logic [4:0]            dec;
   logic [3:0]            dig;
   logic                  digit_ok;
   logic [EW-1:0]         ext;
   logic [EW-1:0]         prod;
   logic [EW-1:0]         sum;
   logic                  ovf;
   logic [3:0]            top_digit;
   logic [1:0]            err_final;

   assign dec = digit_decode(req_char_in);
   assign dig = dec[3:0];
   assign ext = {4'b0, acc_ff};

   always_comb begin
      case (base_ff)
         BASE_BIN: begin
            digit_ok = dec[4] && (dig <= BIN_DIGIT_MAX);
            prod     = ext << 1;
         end
         BASE_DEC: begin
            digit_ok = dec[4] && (dig <= DEC_DIGIT_MAX);
            prod     = (ext << 3) + (ext << 1);
         end
         BASE_HEX: begin
            digit_ok = dec[4];
            prod     = ext << 4;
         end
         default: begin
            digit_ok = 1'b0;
            prod     = ext << 4;
         end
      endcase
   end

   assign sum = prod + EW'(dig);
   assign ovf = |sum[EW-1:VALUE_BITS];

   assign top_digit = out_hex_ff ? sr_ff[PADW-1 -: 4] : {3'b0, sr_ff[PADW-1]};
   // a number that never got a base (lone "0") is a prefix error
   assign err_final = (err_ff != ERR_NONE) ? err_ff :
                      (base_ff == BASE_NONE) ? ERR_PREFIX : ERR_NONE;

   assign status.err      = err_final;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign status.cnt_one  = (cnt_ff == CW'(1));
   assign status.top_zero = (top_digit == 4'd0);

   // number state
   always_comb begin
      out_hex_in    = csr_write ? csr_wdata : out_hex_ff;
      pos_in        = pos_ff;
      base_in       = base_ff;
      acc_in        = acc_ff;
      err_in        = err_ff;
      first_zero_in = first_zero_ff;
      if (cmd.clear) begin
         pos_in        = 2'd0;
         base_in       = BASE_NONE;
         acc_in        = '0;
         err_in        = ERR_NONE;
         first_zero_in = 1'b0;
      end else if (cmd.take) begin
         pos_in = (pos_ff == 2'd2) ? 2'd2 : pos_ff + 2'd1;
         if (err_ff == ERR_NONE) begin
            if (pos_ff == 2'd0) begin
               first_zero_in = (req_char_in == CH_0);
               if (req_char_in >= CH_1 && req_char_in <= CH_9) begin
                  base_in = BASE_DEC;
                  acc_in  = VALUE_BITS'(dig);
               end else if (req_char_in != CH_0) begin
                  err_in = ERR_PREFIX;
               end
            end else if (pos_ff == 2'd1 && first_zero_ff) begin
               if (req_char_in == CH_LB || req_char_in == CH_UB) begin
                  base_in = BASE_BIN;
               end else if (req_char_in == CH_LX || req_char_in == CH_UX) begin
                  base_in = BASE_HEX;
               end else begin
                  err_in = ERR_PREFIX;
               end
            end else if (base_ff == BASE_NONE) begin
               err_in = ERR_PREFIX;
            end else if (!digit_ok) begin
               err_in = ERR_DIGIT;
            end else if (ovf) begin
               err_in = ERR_OVERFLOW;
            end else begin
               acc_in = sum[VALUE_BITS-1:0];
            end
         end
      end
   end

   // output digit shifter, MSB digit on top
   always_comb begin
      sr_in  = sr_ff;
      cnt_in = cnt_ff;
      if (cmd.load) begin
         sr_in  = PADW'(acc_ff);
         cnt_in = out_hex_ff ? CW'(PADW / 4) : CW'(PADW);
      end else if (cmd.shift) begin
         sr_in  = out_hex_ff ? (sr_ff << 4) : (sr_ff << 1);
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_err_in   = rsp_err_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         case (cmd.sel)
            SEL_ZERO: begin
               rsp_char_in = CH_0;
               rsp_end_in  = 1'b0;
               rsp_err_in  = ERR_NONE;
            end
            SEL_BASE: begin
               rsp_char_in = out_hex_ff ? CH_LX : CH_LB;
               rsp_end_in  = 1'b0;
               rsp_err_in  = ERR_NONE;
            end
            SEL_DIGIT: begin
               rsp_char_in = hex_char(top_digit);
               rsp_end_in  = status.cnt_one;
               rsp_err_in  = ERR_NONE;
            end
            default: begin
               rsp_char_in = CH_NUL;
               rsp_end_in  = 1'b1;
               rsp_err_in  = err_final;
            end
         endcase
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_hex_ff    <= 1'b1;
         pos_ff        <= 2'd0;
         base_ff       <= BASE_NONE;
         acc_ff        <= '0;
         err_ff        <= ERR_NONE;
         first_zero_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         out_hex_ff    <= out_hex_in;
         pos_ff        <= pos_in;
         base_ff       <= base_in;
         acc_ff        <= acc_in;
         err_ff        <= err_in;
         first_zero_ff <= first_zero_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sr_ff       <= sr_in;
      cnt_ff      <= cnt_in;
      rsp_char_ff <= rsp_char_in;
      rsp_end_ff  <= rsp_end_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = rsp_char_ff;
   assign rsp_run_end  = rsp_end_ff;
   assign rsp_error    = rsp_err_ff;

endmodule

// ===== design/anbc_ctrl.sv =====
module anbc_ctrl
   import anbc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_is_last,
   output logic            req_stall,
   input  anbc_status_type status,
   output anbc_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IN,
      S_LOAD,
      S_SKIP,
      S_PFX0,
      S_PFX1,
      S_DIG
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.sel   = SEL_ZERO;
      case (state_ff)
         S_IN: begin
            cmd.take = req_valid;
            if (req_valid && req_is_last) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (status.err != ERR_NONE) begin
               if (status.out_free) begin
                  cmd.emit  = 1'b1;
                  cmd.sel   = SEL_ERROR;
                  cmd.clear = 1'b1;
                  state_in  = S_IN;
               end
            end else begin
               cmd.load  = 1'b1;
               cmd.clear = 1'b1;
               state_in  = S_SKIP;
            end
         end
         S_SKIP: begin
            // drop leading zero digits, keep at least one
            if (!status.cnt_one && status.top_zero) begin
               cmd.shift = 1'b1;
            end else begin
               state_in = S_PFX0;
            end
         end
         S_PFX0: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_ZERO;
               state_in = S_PFX1;
            end
         end
         S_PFX1: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_BASE;
               state_in = S_DIG;
            end
         end
         S_DIG: begin
            if (status.out_free) begin
               cmd.emit  = 1'b1;
               cmd.sel   = SEL_DIGIT;
               cmd.shift = 1'b1;
               if (status.cnt_one) begin
                  state_in = S_IN;
               end
            end
         end
         default: begin
            state_in = S_IN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IN;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IN);

endmodule

// ===== design/ascii_number_base_converter.sv =====
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_char_in[7:0], req_is_last
// rsp_      out        rsp_valid/rsp_stall  rsp_char_out[7:0], rsp_run_end, rsp_error[1:0]
// csr_      in         csr_write            csr_wdata (out_hex)
//
// Input characters are taken one per cycle while req_stall is low; one add/compare on the
// accumulator per char. After the last char the value is checked and loaded, leading zero
// digits are skipped, then the output chars ("0", base letter, digits) go out while rsp_stall
// is low; req is stalled meanwhile. An error run is one result, registered from state S_LOAD
// after the last char and held back only while rsp is still held off.
// Reset is synchronous, active high; out_hex resets to 1 (hex output).
// rsp has one output register: input is taken again while the final char waits there.
module ascii_number_base_converter
   import anbc_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_in,
   input  logic       req_is_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_char_out,
   output logic       rsp_run_end,
   output logic [1:0] rsp_error,
   input  logic       csr_write,
   input  logic       csr_wdata
);

   anbc_cmd_type    cmd;
   anbc_status_type status;

   anbc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_is_last (req_is_last),
      .req_stall   (req_stall),
      .status      (status),
      .cmd         (cmd)
   );

   anbc_dp #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_char_in  (req_char_in),
      .csr_write    (csr_write),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .status       (status),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_char_out (rsp_char_out),
      .rsp_run_end  (rsp_run_end),
      .rsp_error    (rsp_error)
   );

endmodule
